@@ hdl/p2b_pkg.sv @@
package p2b_pkg;

  // Request kinds on the input channel
  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_RESIZE = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_NULL = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEAP_START = 2'd0;
  localparam logic [1:0] CFG_HEAP_LIMIT = 2'd1;
  localparam logic [1:0] CFG_GROW_PAGES = 2'd2;

  // Header tag of an allocated block
  localparam logic [7:0] HDR_TAG = 8'hEF;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TAG_CHK,
    S_SIZE0,
    S_SIZE,
    S_ALIGN,
    S_PAD,
    S_PAD2,
    S_CLASS,
    S_REFILL,
    S_CARVE0,
    S_CARVE,
    S_POP_RD,
    S_POP,
    S_BRK,
    S_DIV,
    S_MUL,
    S_GROW,
    S_FAIL,
    S_DONE
  } state_t;

endpackage

@@ hdl/p2b_req_if.sv @@
interface p2b_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [24:0] size_bytes;
  logic [31:0] block_addr;

  modport source(output valid, req_type, size_bytes, block_addr, input ready);
  modport sink(input valid, req_type, size_bytes, block_addr, output ready);
endinterface

@@ hdl/p2b_rsp_if.sv @@
interface p2b_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_addr;
  logic [1:0]  status;
  logic [31:0] usable_bytes;
  logic [24:0] copy_bytes;
  logic [4:0]  bucket_index;
  logic [31:0] used_bytes;

  modport source(output valid, result_addr, status, usable_bytes, copy_bytes,
                 bucket_index, used_bytes, input ready);
  modport sink(input valid, result_addr, status, usable_bytes, copy_bytes,
               bucket_index, used_bytes, output ready);
endinterface

@@ hdl/p2b_cfg_if.sv @@
interface p2b_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/pow2_bucket_heap_allocator.sv @@
// Channel  Dir  Payload                                              Transfer
// req      in   req_type, size_bytes, block_addr                     valid & ready
// rsp      out  result_addr, status, usable_bytes, copy_bytes,       valid & ready
//               bucket_index, used_bytes
// cfg      in   index, data                                          valid & ready
// One request at a time. An allocation scans the size classes one class a cycle.
// Refilling a list writes one link a cycle, up to PAGE_BYTES/8 links; each growth
// of the heap end runs a serial divide, a multiply and a bound check.
// req is ready only in idle.
// rsp holds its result until taken; the next request waits for a free slot.
// Reset is synchronous; the header memory is not cleared and needs no sweep.
module pow2_bucket_heap_allocator #(
  parameter int PAGE_BYTES   = 4096,
  parameter int NUM_BUCKETS  = 30,
  parameter int HEADER_WORDS = 131072
) (
  input logic clk,
  input logic rst,
  p2b_req_if.sink   req,
  p2b_rsp_if.source rsp,
  p2b_cfg_if.sink   cfg
);
  import p2b_pkg::*;

  localparam int PL = $clog2(PAGE_BYTES);
  localparam int PB = PL - 3;
  localparam int CW = $clog2(PAGE_BYTES / 8);
  localparam int BI = $clog2(NUM_BUCKETS);
  localparam logic [35:0] PAGE36 = 36'(PAGE_BYTES);
  localparam logic [33:0] PAGE34 = 34'(PAGE_BYTES);

  function automatic logic [35:0] bsz(input logic [4:0] b);
    return 36'd1 << (6'(b) + 6'd3);
  endfunction

  function automatic logic [35:0] capf(input logic [35:0] sz);
    return (sz < PAGE36) ? sz - 36'd4 : sz + PAGE36 - 36'd4;
  endfunction

  // Control and datapath registers
  state_t      state, state_next, ret, ret_next;
  logic [1:0]  kind, kind_next;
  logic        rsz, rsz_next;
  logic [24:0] n, n_next;
  logic [31:0] cp, cp_next;
  logic [4:0]  b, b_next;
  logic [35:0] onb, onb_next;
  logic [33:0] amt, amt_next;
  logic        is_small, is_small_next;
  logic [31:0] bp, bp_next, be, be_next;
  logic        aligned, aligned_next;
  logic [31:0] usage, usage_next;
  logic [33:0] incr, incr_next;
  logic        ok, ok_next;
  logic [31:0] prev, prev_next, op, op_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [33:0] prod, prod_next;
  logic [31:0] r_addr, r_addr_next, r_cap, r_cap_next;
  logic [1:0]  r_st, r_st_next;
  logic [24:0] r_copy, r_copy_next;
  logic [4:0]  r_b, r_b_next;
  logic [31:0] heads [NUM_BUCKETS];
  logic        hd_we;
  logic [BI-1:0] hd_wi;
  logic [31:0] hd_wd;
  logic [31:0] hlimit;
  logic [6:0]  gpages;

  // Header memory port
  logic        m_we;
  logic [31:0] m_waddr, m_wdata, m_raddr, m_rdata;

  // Divider port
  logic        div_start, div_done;
  logic [33:0] div_q;

  // Output register
  logic        o_load, o_valid;

  p2b_hdr_ram #(.DEPTH(HEADER_WORDS)) u_ram (
    .clk  (clk),
    .we   (m_we),
    .waddr(m_waddr),
    .wdata(m_wdata),
    .raddr(m_raddr),
    .rdata(m_rdata)
  );

  // Shared wires
  logic [33:0] need;
  logic        brk_fast;
  logic [6:0]  geff;
  logic [34:0] step, base, newend;
  logic        grow_ok;
  logic [7:0]  tb;
  logic        tag_bad;
  logic [35:0] tsz, tcap, lower;
  logic        keep;
  logic        size_more;
  logic [35:0] csz, ccap;
  logic [33:0] low, pad;
  logic        b_ok;
  logic [31:0] head_b;
  logic [33:0] dvd;
  logic        cfg_xfer, in_xfer;

  assign in_xfer  = req.valid && req.ready;
  assign cfg_xfer = cfg.valid && cfg.ready;
  assign need     = {2'b0, bp} + incr;
  assign brk_fast = need < {2'b0, be};
  assign geff     = (gpages == 7'd0) ? 7'd1 : gpages;
  assign step     = 35'(geff) << PL;
  assign base     = {3'b0, be} + (35'(prod) << PL);
  assign newend   = base + step;
  assign grow_ok  = (base < {3'b0, hlimit}) && (newend[34:32] == 3'd0);
  assign dvd      = (need - {2'b0, be}) >> PL;
  assign tb       = m_rdata[15:8];
  assign tag_bad  = (m_rdata[7:0] != HDR_TAG) || (tb >= 8'(NUM_BUCKETS));
  assign tsz      = bsz(tb[4:0]);
  assign tcap     = capf(tsz);
  assign lower    = (tb == 8'd0) ? 36'd0 : capf(tsz >> 1);
  assign keep     = ({11'b0, n} <= tcap) && ({11'b0, n} > lower);
  assign size_more = is_small ? ({9'b0, n} + 34'd4 > amt)
                              : ({9'b0, n} > amt + PAGE34 - 34'd4);
  assign csz      = bsz(b);
  assign ccap     = capf(csz);
  assign low      = 34'(prev[PL-1:0]);
  assign pad      = (low <= PAGE34 - 34'd4) ? PAGE34 - 34'd4 - low
                                            : PAGE34 + PAGE34 - 34'd4 - low;
  assign b_ok     = 6'(b) < 6'(NUM_BUCKETS);
  assign head_b   = heads[b[BI-1:0]];

  p2b_div #(.W(34), .DV(7)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dvd),
    .divisor (geff),
    .done    (div_done),
    .quotient(div_q)
  );

  assign req.ready = (state == S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (req.req_type == REQ_ALLOC ||
              (req.req_type == REQ_RESIZE && req.block_addr == 32'd0)) begin
            state_next = S_SIZE0;
          end else if (req.block_addr == 32'd0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_TAG_CHK;
          end
        end
      end
      S_TAG_CHK: begin
        if (!tag_bad && kind == REQ_RESIZE && !keep) begin
          state_next = S_SIZE0;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SIZE0: state_next = S_SIZE;
      S_SIZE:  state_next = size_more ? S_SIZE : S_ALIGN;
      S_ALIGN: state_next = aligned ? S_CLASS : S_BRK;
      S_PAD: begin
        if (!ok) begin
          state_next = S_FAIL;
        end else if (pad == 34'd0) begin
          state_next = S_CLASS;
        end else begin
          state_next = S_BRK;
        end
      end
      S_PAD2: state_next = ok ? S_CLASS : S_FAIL;
      S_CLASS: begin
        if (!b_ok) begin
          state_next = S_FAIL;
        end else if (head_b != 32'd0) begin
          state_next = S_POP_RD;
        end else begin
          state_next = S_REFILL;
        end
      end
      S_REFILL: state_next = (6'(b) + 6'd3 >= 6'd31) ? S_FAIL : S_BRK;
      S_CARVE0: state_next = ok ? S_CARVE : S_FAIL;
      S_CARVE:  state_next = (cnt == '0) ? S_POP_RD : S_CARVE;
      S_POP_RD: state_next = S_POP;
      S_POP:    state_next = S_DONE;
      S_BRK: begin
        if (bp == 32'd0 || brk_fast) begin
          state_next = ret;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV:  state_next = div_done ? S_MUL : S_DIV;
      S_MUL:  state_next = S_GROW;
      S_GROW: state_next = ret;
      S_FAIL: state_next = S_DONE;
      S_DONE: state_next = (!o_valid || rsp.ready) ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    ret_next      = ret;
    kind_next     = kind;
    rsz_next      = rsz;
    n_next        = n;
    cp_next       = cp;
    b_next        = b;
    onb_next      = onb;
    amt_next      = amt;
    is_small_next = is_small;
    bp_next       = bp;
    be_next       = be;
    aligned_next  = aligned;
    usage_next    = usage;
    incr_next     = incr;
    ok_next       = ok;
    prev_next     = prev;
    op_next       = op;
    cnt_next      = cnt;
    prod_next     = prod;
    r_addr_next   = r_addr;
    r_st_next     = r_st;
    r_cap_next    = r_cap;
    r_copy_next   = r_copy;
    r_b_next      = r_b;
    hd_we         = 1'b0;
    hd_wi         = b[BI-1:0];
    hd_wd         = 32'd0;
    m_we          = 1'b0;
    m_waddr       = op;
    m_wdata       = 32'd0;
    m_raddr       = req.block_addr - 32'd4;
    div_start     = 1'b0;
    o_load        = 1'b0;
    case (state)
      S_IDLE: begin
        // Latch request, clear result
        if (in_xfer) begin
          n_next      = req.size_bytes;
          cp_next     = req.block_addr;
          kind_next   = req.req_type;
          rsz_next    = 1'b0;
          r_addr_next = 32'd0;
          r_st_next   = ST_OK;
          r_cap_next  = 32'd0;
          r_copy_next = 25'd0;
          r_b_next    = 5'd0;
          if (req.req_type == REQ_RESIZE && req.block_addr != 32'd0 &&
              req.size_bytes == 25'd0) begin
            kind_next = REQ_FREE;
          end
          if (req.req_type != REQ_ALLOC && req.block_addr == 32'd0 &&
              req.req_type != REQ_RESIZE) begin
            r_st_next = ST_NULL;
          end
        end
      end
      S_TAG_CHK: begin
        if (tag_bad) begin
          r_st_next = ST_BAD;
        end else begin
          r_b_next   = tb[4:0];
          r_cap_next = tcap[31:0];
          if (kind == REQ_RESIZE && keep) begin
            r_addr_next = cp;
          end else if (kind != REQ_QUERY) begin
            // Push the block on its list
            m_we       = 1'b1;
            m_waddr    = cp - 32'd4;
            m_wdata    = heads[tb[BI-1:0]];
            hd_we      = 1'b1;
            hd_wi      = tb[BI-1:0];
            hd_wd      = cp - 32'd4;
            usage_next = usage - tsz[31:0];
            if (kind == REQ_RESIZE) begin
              rsz_next   = 1'b1;
              onb_next   = tcap;
              r_cap_next = 32'd0;
            end
          end
        end
      end
      S_SIZE0: begin
        is_small_next = {9'b0, n} <= PAGE34 - 34'd4;
        amt_next      = ({9'b0, n} <= PAGE34 - 34'd4) ? 34'd8 : PAGE34;
        b_next        = ({9'b0, n} <= PAGE34 - 34'd4) ? 5'd0 : 5'(PB);
      end
      S_SIZE: begin
        if (size_more) begin
          amt_next = amt << 1;
          b_next   = b + 5'd1;
        end else begin
          r_b_next = b;
        end
      end
      S_ALIGN: begin
        if (!aligned) begin
          aligned_next = 1'b1;
          incr_next    = 34'd0;
          ret_next     = S_PAD;
        end
      end
      S_PAD: begin
        incr_next = pad;
        ret_next  = S_PAD2;
      end
      S_REFILL: begin
        incr_next = (csz < PAGE36) ? PAGE34 : csz[33:0] + PAGE34;
        ret_next  = S_CARVE0;
      end
      S_CARVE0: begin
        if (ok) begin
          hd_we    = 1'b1;
          hd_wd    = prev;
          op_next  = prev;
          cnt_next = (csz < PAGE36) ? CW'((PAGE36 >> (6'(b) + 6'd3)) - 36'd1)
                                    : '0;
        end
      end
      S_CARVE: begin
        // Link one carved block a cycle, last link ends the list
        m_we = 1'b1;
        if (cnt != '0) begin
          m_wdata  = op + csz[31:0];
          op_next  = op + csz[31:0];
          cnt_next = cnt - 1'b1;
        end
      end
      S_POP_RD: begin
        m_raddr = head_b;
        op_next = head_b;
      end
      S_POP: begin
        hd_we       = 1'b1;
        hd_wd       = m_rdata;
        m_we        = 1'b1;
        m_wdata     = {16'd0, 3'd0, b, HDR_TAG};
        usage_next  = usage + csz[31:0];
        r_addr_next = op + 32'd4;
        r_cap_next  = ccap[31:0];
        if (rsz && (op + 32'd4 != cp)) begin
          r_copy_next = ({11'b0, n} < onb) ? n : onb[24:0];
        end
      end
      S_BRK: begin
        if (bp == 32'd0) begin
          ok_next = 1'b0;
        end else if (brk_fast) begin
          ok_next   = 1'b1;
          prev_next = bp;
          bp_next   = need[31:0];
        end else begin
          div_start = 1'b1;
        end
      end
      S_MUL: begin
        prod_next = 34'(div_q * 34'(geff));
      end
      S_GROW: begin
        ok_next = grow_ok;
        if (grow_ok) begin
          be_next   = newend[31:0];
          prev_next = bp;
          bp_next   = need[31:0];
        end
      end
      S_FAIL: begin
        r_st_next   = ST_OOM;
        r_addr_next = 32'd0;
        r_cap_next  = 32'd0;
        r_copy_next = 25'd0;
      end
      S_DONE: begin
        o_load = !o_valid || rsp.ready;
      end
      default: begin
      end
    endcase
    // Break follows heap_start until the first alignment
    if (cfg_xfer && cfg.index == CFG_HEAP_START && !aligned) begin
      bp_next = cfg.data;
      be_next = cfg.data;
    end
  end

  assign cfg.ready = 1'b1;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret     <= S_IDLE;
      aligned <= 1'b0;
      usage   <= 32'd0;
      bp      <= 32'd4063232;
      be      <= 32'd4063232;
      hlimit  <= 32'd29331325;
      gpages  <= 7'd10;
      o_valid <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        heads[i] <= 32'd0;
      end
    end else begin
      state   <= state_next;
      ret     <= ret_next;
      aligned <= aligned_next;
      usage   <= usage_next;
      bp      <= bp_next;
      be      <= be_next;
      if (hd_we) begin
        heads[hd_wi] <= hd_wd;
      end
      if (cfg_xfer) begin
        case (cfg.index)
          CFG_HEAP_LIMIT: hlimit <= cfg.data;
          CFG_GROW_PAGES: gpages <= cfg.data[6:0];
          default: begin
          end
        endcase
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind     <= kind_next;
    rsz      <= rsz_next;
    n        <= n_next;
    cp       <= cp_next;
    b        <= b_next;
    onb      <= onb_next;
    amt      <= amt_next;
    is_small <= is_small_next;
    incr     <= incr_next;
    ok       <= ok_next;
    prev     <= prev_next;
    op       <= op_next;
    cnt      <= cnt_next;
    prod     <= prod_next;
    r_addr   <= r_addr_next;
    r_st     <= r_st_next;
    r_cap    <= r_cap_next;
    r_copy   <= r_copy_next;
    r_b      <= r_b_next;
    if (o_load) begin
      rsp.result_addr  <= r_addr;
      rsp.status       <= r_st;
      rsp.usable_bytes <= r_cap;
      rsp.copy_bytes   <= r_copy;
      rsp.bucket_index <= r_b;
      rsp.used_bytes   <= usage;
    end
  end

  assign rsp.valid = o_valid;
endmodule

@@ hdl/p2b_hdr_ram.sv @@
module p2b_hdr_ram #(
  parameter int DEPTH = 131072
) (
  input  logic        clk,
  input  logic        we,
  input  logic [31:0] waddr,
  input  logic [31:0] wdata,
  input  logic [31:0] raddr,
  output logic [31:0] rdata
);
  localparam int AW = $clog2(DEPTH);

  logic [31:0] mem [DEPTH];

  // One header word per 8-byte slot of the byte address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[3 +: AW]] <= wdata;
    end
    rdata <= mem[raddr[3 +: AW]];
  end
endmodule

@@ hdl/p2b_div.sv @@
module p2b_div #(
  parameter int W  = 34,
  parameter int DV = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [DV-1:0] divisor,
  output logic          done,
  output logic [W-1:0]  quotient
);
  localparam int CNW = $clog2(W + 1);

  logic          busy;
  logic [CNW-1:0] cnt;
  logic [DV-1:0] rem;
  logic [DV:0]   shifted;
  logic [DV+1:0] diff;

  assign shifted = {rem, quotient[W-1]};
  assign diff    = {1'b0, shifted} - {2'b0, divisor};

  // Restoring divide, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNW'(W);
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        if (diff[DV+1]) begin
          rem <= shifted[DV-1:0];
        end else begin
          rem <= diff[DV-1:0];
        end
        quotient <= {quotient[W-2:0], ~diff[DV+1]};
        cnt      <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
